/* hw/rtl/gpd_pkg.sv */
// shared constants and decode functions for the gamepad report decoder
package gpd_pkg;

   localparam logic [7:0] REPORT_ID    = 8'h30;
   localparam int         NUM_BUTTONS  = 14;
   localparam int         NUM_AXES     = 4;
   localparam int         AXIS_W       = 12;
   localparam int         CAL_W        = 36;
   localparam int         QUOT_BITS    = 8;
   localparam int         NUM_W        = AXIS_W + 7;
   localparam int         DIV_W        = NUM_W + 1;
   // setup stage, one stage per quotient bit, result stage
   localparam int         LANE_LAT     = QUOT_BITS + 2;
   localparam int         CSR_ADDR_W   = 6;
   localparam int         CSR_DATA_W   = 64;

   localparam logic [3:0] HAT_CENTRED  = 4'd8;

   typedef enum logic [2:0] {
      CSR_LEFT_X  = 3'd0,
      CSR_LEFT_Y  = 3'd1,
      CSR_RIGHT_X = 3'd2,
      CSR_RIGHT_Y = 3'd3,
      CSR_MASK    = 3'd4
   } csr_index_type;

   typedef logic [4:0] btn_src_type [NUM_BUTTONS];
   localparam btn_src_type BTN_SRC = '{5'd2, 5'd3, 5'd0, 5'd1, 5'd22, 5'd6, 5'd23,
                                       5'd7, 5'd8, 5'd9, 5'd11, 5'd10, 5'd12, 5'd13};

   function automatic logic [NUM_BUTTONS-1:0] map_buttons(input logic [23:0] bytes_in);
      logic [NUM_BUTTONS-1:0] res;
      res = '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         res[i] = bytes_in[BTN_SRC[i]];
      end
      return res;
   endfunction

   // opposing pad directions cancel out
   function automatic logic [3:0] pad_to_hat(input logic [23:0] bytes_in);
      logic up, down, left, right;
      logic [3:0] res;
      down  = bytes_in[16] & ~bytes_in[17];
      up    = bytes_in[17] & ~bytes_in[16];
      right = bytes_in[18] & ~bytes_in[19];
      left  = bytes_in[19] & ~bytes_in[18];
      case ({up, down, left, right})
         4'b1000: res = 4'd0;
         4'b1001: res = 4'd1;
         4'b0001: res = 4'd2;
         4'b0101: res = 4'd3;
         4'b0100: res = 4'd4;
         4'b0110: res = 4'd5;
         4'b0010: res = 4'd6;
         4'b1010: res = 4'd7;
         default: res = HAT_CENTRED;
      endcase
      return res;
   endfunction

endpackage

/* hw/rtl/gamepad_report_decoder.sv */
// gamepad report decoder top level: csr block, four axis lanes and merge stage
//
// channel   direction  handshake                  payload
// req       in         req_valid / req_stall      report_id long_enough button_bytes sticks
// rsp       out        rsp_valid / rsp_stall      accepted buttons hat four axes
// csr       in/out     psel penable pwrite pready paddr pwdata prdata
//
// one item per cycle while not held; each item passes lane setup, eight divider stages
// (one quotient bit each), lane result and the merge register.
// the whole pipeline holds while a result waits with rsp_stall high.
// reset clears valid bits and calibration registers; no clearing pass.
module gamepad_report_decoder (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [7:0]                       req_report_id,
   input  logic                             req_long_enough,
   input  logic [23:0]                      req_button_bytes,
   input  logic [23:0]                      req_left_stick,
   input  logic [23:0]                      req_right_stick,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_accepted,
   output logic [13:0]                      rsp_buttons,
   output logic [3:0]                       rsp_hat,
   output logic [7:0]                       rsp_left_x,
   output logic [7:0]                       rsp_left_y,
   output logic [7:0]                       rsp_right_x,
   output logic [7:0]                       rsp_right_y,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [gpd_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [gpd_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [gpd_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);
   import gpd_pkg::*;

   logic [CAL_W-1:0]    cal_ff [NUM_AXES];
   logic [NUM_AXES-1:0] mask_ff;
   csr_index_type       csr_idx_w;
   logic                csr_wr_w;

   logic                   advance;
   logic                   accepted_w;
   logic                   valid_ff [LANE_LAT];
   logic                   acc_ff   [LANE_LAT];
   logic [NUM_BUTTONS-1:0] btn_ff   [LANE_LAT];
   logic [3:0]             hat_ff   [LANE_LAT];
   logic [7:0]             lane_axis [NUM_AXES];
   logic [AXIS_W-1:0]      lane_raw  [NUM_AXES];

   logic                   rsp_valid_ff, rsp_acc_ff;
   logic [NUM_BUTTONS-1:0] rsp_btn_ff;
   logic [3:0]             rsp_hat_ff;
   logic [7:0]             rsp_axis_ff [NUM_AXES];

   // configuration port
   assign pready    = 1'b1;
   assign csr_idx_w = csr_index_type'(paddr[CSR_ADDR_W-1:3]);
   assign csr_wr_w  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            cal_ff[i] <= '0;
         end
         mask_ff <= '0;
      end else if (csr_wr_w) begin
         unique case (csr_idx_w)
            CSR_LEFT_X:  cal_ff[0] <= pwdata[CAL_W-1:0];
            CSR_LEFT_Y:  cal_ff[1] <= pwdata[CAL_W-1:0];
            CSR_RIGHT_X: cal_ff[2] <= pwdata[CAL_W-1:0];
            CSR_RIGHT_Y: cal_ff[3] <= pwdata[CAL_W-1:0];
            CSR_MASK:    mask_ff   <= pwdata[NUM_AXES-1:0];
            default:     ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx_w)
         CSR_LEFT_X:  prdata = CSR_DATA_W'(cal_ff[0]);
         CSR_LEFT_Y:  prdata = CSR_DATA_W'(cal_ff[1]);
         CSR_RIGHT_X: prdata = CSR_DATA_W'(cal_ff[2]);
         CSR_RIGHT_Y: prdata = CSR_DATA_W'(cal_ff[3]);
         CSR_MASK:    prdata = CSR_DATA_W'(mask_ff);
         default:     prdata = '0;
      endcase
   end

   // pipeline moves as one unless the merge register holds an untaken item
   assign advance    = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !advance;
   assign accepted_w = (req_report_id == REPORT_ID) && req_long_enough;

   assign lane_raw[0] = req_left_stick[AXIS_W-1:0];
   assign lane_raw[1] = req_left_stick[2*AXIS_W-1:AXIS_W];
   assign lane_raw[2] = req_right_stick[AXIS_W-1:0];
   assign lane_raw[3] = req_right_stick[2*AXIS_W-1:AXIS_W];

   for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
      gpd_axis_lane u_lane (
         .clock      (clock),
         .advance    (advance),
         .raw        (lane_raw[a]),
         .cal        (cal_ff[a]),
         .calibrated (mask_ff[a]),
         .inverted   (a[0] == 1'b1),
         .axis_out   (lane_axis[a])
      );
   end

   // side pipe for the fields that need no divider
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < LANE_LAT; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else if (advance) begin
         valid_ff[0] <= req_valid;
         for (int s = 1; s < LANE_LAT; s++) begin
            valid_ff[s] <= valid_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         acc_ff[0] <= accepted_w;
         btn_ff[0] <= map_buttons(req_button_bytes);
         hat_ff[0] <= pad_to_hat(req_button_bytes);
         for (int s = 1; s < LANE_LAT; s++) begin
            acc_ff[s] <= acc_ff[s-1];
            btn_ff[s] <= btn_ff[s-1];
            hat_ff[s] <= hat_ff[s-1];
         end
      end
   end

   // merge stage: rejected reports give all zero fields
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= valid_ff[LANE_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_acc_ff <= acc_ff[LANE_LAT-1];
         rsp_btn_ff <= acc_ff[LANE_LAT-1] ? btn_ff[LANE_LAT-1] : '0;
         rsp_hat_ff <= acc_ff[LANE_LAT-1] ? hat_ff[LANE_LAT-1] : '0;
         for (int a = 0; a < NUM_AXES; a++) begin
            rsp_axis_ff[a] <= acc_ff[LANE_LAT-1] ? lane_axis[a] : '0;
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_accepted = rsp_acc_ff;
   assign rsp_buttons  = rsp_btn_ff;
   assign rsp_hat      = rsp_hat_ff;
   assign rsp_left_x   = rsp_axis_ff[0];
   assign rsp_left_y   = rsp_axis_ff[1];
   assign rsp_right_x  = rsp_axis_ff[2];
   assign rsp_right_y  = rsp_axis_ff[3];

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_accepted |-> rsp_buttons == '0 && rsp_hat == '0 &&
         rsp_left_x == '0 && rsp_left_y == '0 && rsp_right_x == '0 && rsp_right_y == '0)
      else $error("rejected item carries non-zero fields");

   a_hat_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hat <= HAT_CENTRED)
      else $error("hat value out of range");

   a_stall_link: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall does not follow output back-pressure");

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_left_y) && $stable(rsp_buttons))
      else $error("held result changed");

endmodule

/* hw/rtl/gpd_axis_lane.sv */
// one stick axis lane: calibration scaling with a pipelined restoring divider, or raw bypass when uncalibrated
module gpd_axis_lane (
   input  logic                         clock,
   input  logic                         advance,
   input  logic [gpd_pkg::AXIS_W-1:0]   raw,
   input  logic [gpd_pkg::CAL_W-1:0]    cal,
   input  logic                         calibrated,
   input  logic                         inverted,
   output logic [7:0]                   axis_out
);
   import gpd_pkg::*;

   logic [AXIS_W-1:0]        center_w, below_w, above_w, span_w;
   logic signed [AXIS_W+1:0] delta_w, sdelta_w, ndelta_w;
   logic                     neg_w, ovf_w;
   logic [AXIS_W-1:0]        mag_w;
   logic [NUM_W-1:0]         num_w;
   logic [AXIS_W:0]          uinv_w;
   logic [7:0]               byp_w;

   logic [NUM_W-1:0]     rem_ff  [QUOT_BITS+1];
   logic [NUM_W-1:0]     rem_in  [QUOT_BITS+1];
   logic [QUOT_BITS-1:0] quot_ff [QUOT_BITS+1];
   logic [QUOT_BITS-1:0] quot_in [QUOT_BITS+1];
   logic [AXIS_W-1:0]    span_ff [QUOT_BITS+1];
   logic                 neg_ff  [QUOT_BITS+1];
   logic                 ovf_ff  [QUOT_BITS+1];
   logic                 cal_ff  [QUOT_BITS+1];
   logic [7:0]           byp_ff  [QUOT_BITS+1];
   logic [7:0]           axis_ff, axis_in;
   logic [DIV_W-1:0]     trial_w [QUOT_BITS+1];
   logic [QUOT_BITS-1:0] q_w;
   logic [QUOT_BITS:0]   low_w;

   always_comb begin
      center_w = cal[AXIS_W-1:0];
      below_w  = cal[2*AXIS_W-1:AXIS_W];
      above_w  = cal[3*AXIS_W-1:2*AXIS_W];
      delta_w  = $signed({2'b00, raw}) - $signed({2'b00, center_w});
      span_w   = delta_w[AXIS_W+1] ? below_w : above_w;
      if (span_w == '0) begin
         span_w = AXIS_W'(1);
      end
      sdelta_w = inverted ? -delta_w : delta_w;
      ndelta_w = -sdelta_w;
      neg_w    = sdelta_w[AXIS_W+1];
      mag_w    = neg_w ? ndelta_w[AXIS_W-1:0] : sdelta_w[AXIS_W-1:0];
      // times 128 for a negative (possibly inverted) delta, times 127 otherwise
      num_w    = neg_w ? {mag_w, 7'b0} : ({mag_w, 7'b0} - {7'b0, mag_w});
      ovf_w    = {1'b0, num_w} >= {span_w, 8'b0};
      uinv_w   = (AXIS_W+1)'(4096) - {1'b0, raw};
      byp_w    = inverted ? (uinv_w[AXIS_W] ? 8'd255 : uinv_w[AXIS_W-1:4]) : raw[AXIS_W-1:4];
   end

   always_comb begin
      rem_in[0]  = num_w;
      quot_in[0] = '0;
      trial_w[0] = '0;
      for (int s = 1; s <= QUOT_BITS; s++) begin
         trial_w[s] = DIV_W'({8'b0, span_ff[s-1]}) << (QUOT_BITS - s);
         if ({1'b0, rem_ff[s-1]} >= trial_w[s]) begin
            rem_in[s]  = rem_ff[s-1] - trial_w[s][NUM_W-1:0];
            quot_in[s] = {quot_ff[s-1][QUOT_BITS-2:0], 1'b1};
         end else begin
            rem_in[s]  = rem_ff[s-1];
            quot_in[s] = {quot_ff[s-1][QUOT_BITS-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      q_w   = quot_ff[QUOT_BITS];
      low_w = (QUOT_BITS+1)'(128) - {1'b0, q_w};
      if (!cal_ff[QUOT_BITS]) begin
         axis_in = byp_ff[QUOT_BITS];
      end else if (!neg_ff[QUOT_BITS]) begin
         axis_in = (ovf_ff[QUOT_BITS] || q_w[7]) ? 8'd255 : {1'b1, q_w[6:0]};
      end else begin
         axis_in = (ovf_ff[QUOT_BITS] || low_w[QUOT_BITS]) ? 8'd0 : low_w[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0]  <= rem_in[0];
         quot_ff[0] <= quot_in[0];
         span_ff[0] <= span_w;
         neg_ff[0]  <= neg_w;
         ovf_ff[0]  <= ovf_w;
         cal_ff[0]  <= calibrated;
         byp_ff[0]  <= byp_w;
         for (int s = 1; s <= QUOT_BITS; s++) begin
            rem_ff[s]  <= rem_in[s];
            quot_ff[s] <= quot_in[s];
            span_ff[s] <= span_ff[s-1];
            neg_ff[s]  <= neg_ff[s-1];
            ovf_ff[s]  <= ovf_ff[s-1];
            cal_ff[s]  <= cal_ff[s-1];
            byp_ff[s]  <= byp_ff[s-1];
         end
         axis_ff <= axis_in;
      end
   end

   assign axis_out = axis_ff;

endmodule
